@@ hw/rtl/fpa_pkg.sv @@
// Shared types and constants for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int REM_W     = DATA_W + 1;
   localparam int REQ_W     = 72;
   localparam int RSP_W     = 40;

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_MIN      = 4'd4,
      MODE_MAX      = 4'd5,
      MODE_INC      = 4'd6,
      MODE_DEC      = 4'd7,
      MODE_TO_INT   = 4'd8,
      MODE_FROM_INT = 4'd9
   } mode_type;

   typedef struct packed {
      logic              valid;
      logic [3:0]        mode;
      logic              lt;
      logic              eq;
      logic              gt;
      logic [DATA_W-1:0] value;
      logic              ovf;
      logic              neg;
      logic              dz;
      logic [DATA_W-1:0] divisor;
      logic [REM_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
   } pipe_type;

endpackage
`default_nettype wire

@@ hw/rtl/fixed_point_alu_top.sv @@
// Fixed-point ALU top level: pipelined add/sub/inc/dec/mul/div/min/max/compare and int-conversion datapath.
//
// channel | dir | fields
// req     | in  | mode, operand_a, operand_b
// rsp     | out | result_value, a_less, a_equal, a_greater, overflow, divide_by_zero
//
// One item per cycle while the output is not stalled; the pipeline depth is
// set by the restoring divider, one quotient bit per stage.
// All operations travel the same depth so results leave in order.
// A stalled output register freezes every stage; bubbles carry a cleared valid.
// Synchronous reset clears only the valid bits.
`default_nettype none
module fixed_point_alu_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [3:0] mode, [35:4] operand_a, [67:36] operand_b, rest zero
   input  wire logic [fpa_pkg::REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [31:0] result_value, [32] a_less, [33] a_equal, [34] a_greater,
   // [35] overflow, [36] divide_by_zero, rest zero
   output logic [fpa_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int F  = fpa_pkg::FRAC_BITS;
   localparam int DW = fpa_pkg::DATA_W;
   localparam int NW = fpa_pkg::NUM_W;
   localparam int RW = fpa_pkg::REM_W;
   localparam int NSTG = NW + 2;

   logic advance;

   logic          in_valid_ff;
   logic [3:0]    in_mode_ff;
   logic [DW-1:0] in_a_ff;
   logic [DW-1:0] in_b_ff;

   fpa_pkg::pipe_type  p_ff [0:NSTG-1];
   fpa_pkg::pipe_type  p0_in;
   fpa_pkg::pipe_type  p1_in;
   logic signed [63:0] prod_ff;

   logic                     rsp_valid_ff;
   logic [fpa_pkg::RSP_W-1:0] rsp_data_ff;
   logic [fpa_pkg::RSP_W-1:0] rsp_data_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
      if (advance) begin
         in_mode_ff <= req_tdata[3:0];
         in_a_ff    <= req_tdata[35:4];
         in_b_ff    <= req_tdata[67:36];
      end
   end

   // simple ops, compares, divider setup
   logic [DW:0]   sum_add, sum_sub, sum_inc, sum_dec;
   logic [DW-1:0] abs_a, abs_b;
   logic          a_lt;
   always_comb begin
      sum_add = {in_a_ff[DW-1], in_a_ff} + {in_b_ff[DW-1], in_b_ff};
      sum_sub = {in_a_ff[DW-1], in_a_ff} - {in_b_ff[DW-1], in_b_ff};
      sum_inc = {in_a_ff[DW-1], in_a_ff} + (DW+1)'(1);
      sum_dec = {in_a_ff[DW-1], in_a_ff} - (DW+1)'(1);
      abs_a   = in_a_ff[DW-1] ? (~in_a_ff + DW'(1)) : in_a_ff;
      abs_b   = in_b_ff[DW-1] ? (~in_b_ff + DW'(1)) : in_b_ff;
      a_lt    = $signed(in_a_ff) < $signed(in_b_ff);

      p0_in         = '0;
      p0_in.valid   = in_valid_ff;
      p0_in.mode    = in_mode_ff;
      p0_in.lt      = a_lt;
      p0_in.eq      = in_a_ff == in_b_ff;
      p0_in.gt      = !a_lt && (in_a_ff != in_b_ff);
      p0_in.neg     = in_a_ff[DW-1] ^ in_b_ff[DW-1];
      p0_in.dz      = in_b_ff == '0;
      p0_in.divisor = abs_b;
      p0_in.rem     = '0;
      p0_in.quo     = {abs_a, F'(0)};
      case (fpa_pkg::mode_type'(in_mode_ff))
         fpa_pkg::MODE_ADD: begin
            p0_in.value = sum_add[DW-1:0];
            p0_in.ovf   = sum_add[DW] != sum_add[DW-1];
         end
         fpa_pkg::MODE_SUB: begin
            p0_in.value = sum_sub[DW-1:0];
            p0_in.ovf   = sum_sub[DW] != sum_sub[DW-1];
         end
         fpa_pkg::MODE_INC: begin
            p0_in.value = sum_inc[DW-1:0];
            p0_in.ovf   = sum_inc[DW] != sum_inc[DW-1];
         end
         fpa_pkg::MODE_DEC: begin
            p0_in.value = sum_dec[DW-1:0];
            p0_in.ovf   = sum_dec[DW] != sum_dec[DW-1];
         end
         fpa_pkg::MODE_MIN: begin
            p0_in.value = a_lt ? in_a_ff : in_b_ff;
         end
         fpa_pkg::MODE_MAX: begin
            p0_in.value = a_lt ? in_b_ff : in_a_ff;
         end
         fpa_pkg::MODE_TO_INT: begin
            p0_in.value = DW'($signed(in_a_ff) >>> F);
         end
         fpa_pkg::MODE_FROM_INT: begin
            p0_in.value = {in_a_ff[DW-1-F:0], F'(0)};
            p0_in.ovf   = in_a_ff[DW-1:DW-1-F] != {(F+1){in_a_ff[DW-1]}};
         end
         default: begin
            p0_in.value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff[0].valid <= 1'b0;
      end else if (advance) begin
         p_ff[0].valid <= p0_in.valid;
      end
      if (advance) begin
         p_ff[0][$bits(fpa_pkg::pipe_type)-2:0] <= p0_in[$bits(fpa_pkg::pipe_type)-2:0];
         prod_ff <= $signed(in_a_ff) * $signed(in_b_ff);
      end
   end

   // multiply: truncate toward zero, range check
   logic [63:0] prod_adj;
   logic [63:0] prod_sh;
   always_comb begin
      prod_adj = prod_ff + (prod_ff[63] ? ((64'd1 << F) - 64'd1) : 64'd0);
      prod_sh  = 64'($signed(prod_adj) >>> F);
      p1_in    = p_ff[0];
      if (fpa_pkg::mode_type'(p_ff[0].mode) == fpa_pkg::MODE_MUL) begin
         p1_in.value = prod_sh[DW-1:0];
         p1_in.ovf   = prod_sh[63:DW-1] != {(64-DW+1){prod_sh[DW-1]}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff[1].valid <= 1'b0;
      end else if (advance) begin
         p_ff[1].valid <= p1_in.valid;
      end
      if (advance) begin
         p_ff[1][$bits(fpa_pkg::pipe_type)-2:0] <= p1_in[$bits(fpa_pkg::pipe_type)-2:0];
      end
   end

   // restoring divider, one quotient bit per stage
   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_div
         fpa_pkg::pipe_type st_in;
         logic [RW-1:0]     r2;
         logic              ge;
         always_comb begin
            st_in = p_ff[k+1];
            r2    = {p_ff[k+1].rem[RW-2:0], p_ff[k+1].quo[NW-1]};
            ge    = r2 >= {1'b0, p_ff[k+1].divisor};
            st_in.rem = ge ? (r2 - {1'b0, p_ff[k+1].divisor}) : r2;
            st_in.quo = {p_ff[k+1].quo[NW-2:0], ge};
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               p_ff[k+2].valid <= 1'b0;
            end else if (advance) begin
               p_ff[k+2].valid <= st_in.valid;
            end
            if (advance) begin
               p_ff[k+2][$bits(fpa_pkg::pipe_type)-2:0] <=
                  st_in[$bits(fpa_pkg::pipe_type)-2:0];
            end
         end
      end
   endgenerate

   // quotient sign and range, output packing
   fpa_pkg::pipe_type fin;
   logic [DW-1:0]     res_val;
   logic              res_ovf;
   logic              res_dz;
   always_comb begin
      fin     = p_ff[NSTG-1];
      res_val = fin.value;
      res_ovf = fin.ovf;
      res_dz  = 1'b0;
      if (fpa_pkg::mode_type'(fin.mode) == fpa_pkg::MODE_DIV) begin
         if (fin.dz) begin
            res_val = '0;
            res_ovf = 1'b0;
            res_dz  = 1'b1;
         end else if (fin.neg) begin
            res_val = ~fin.quo[DW-1:0] + DW'(1);
            res_ovf = (fin.quo[NW-1:DW] != '0) ||
                      (fin.quo[DW-1] && (fin.quo[DW-2:0] != '0));
         end else begin
            res_val = fin.quo[DW-1:0];
            res_ovf = fin.quo[NW-1:DW-1] != '0;
         end
      end
      rsp_data_in = {3'b000, res_dz, res_ovf, fin.gt, fin.eq, fin.lt, res_val};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin.valid;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire
